// ----- hdl/vfsd_pkg.sv -----
package vfsd_pkg;

  localparam int NUM_SWITCHES = 8;
  localparam int SWITCH_WIDTH = 8;
  localparam logic [SWITCH_WIDTH-1:0] SWITCH_MASK = SWITCH_WIDTH'((64'd1 << NUM_SWITCHES) - 64'd1);

  localparam int APB_ADDR_WIDTH = 5;
  localparam logic [31:0] MS_PER_MINUTE = 32'd60000;

  localparam logic [15:0] CO2_HIGH_RESET = 16'd1200;
  localparam logic [15:0] CO2_LOW_RESET = 16'd800;
  localparam logic [15:0] CO2_HYST_RESET = 16'd100;
  localparam logic [10:0] COOLDOWN_MIN_RESET = 11'd5;
  localparam logic [31:0] COOLDOWN_MS_RESET = 32'({21'd0, COOLDOWN_MIN_RESET}) * MS_PER_MINUTE;

  typedef enum logic [2:0] {
    REG_CO2_HIGH    = 3'd0,
    REG_CO2_LOW     = 3'd1,
    REG_CO2_HYST    = 3'd2,
    REG_COOLDOWN    = 3'd3,
    REG_WIN_START   = 3'd4,
    REG_WIN_END     = 3'd5,
    REG_RUN_MINUTES = 3'd6,
    REG_SCHED_MODE  = 3'd7
  } reg_index_t;

  localparam logic [1:0] FAN_OFF = 2'd0;
  localparam logic [1:0] FAN_LOW = 2'd1;
  localparam logic [1:0] FAN_HIGH = 2'd2;
  localparam logic [1:0] SPEED_UNUSED = 2'd3;

  localparam logic [2:0] BY_SWITCH = 3'd0;
  localparam logic [2:0] BY_COOLDOWN = 3'd1;
  localparam logic [2:0] BY_CO2 = 3'd2;
  localparam logic [2:0] BY_SCHEDULE = 3'd3;
  localparam logic [2:0] BY_DEFAULT = 3'd4;

  typedef struct packed {
    logic [15:0] co2_hi;
    logic [15:0] co2_low;
    logic [15:0] co2_hyst;
    logic [31:0] cooldown_ms;
    logic [31:0] cooldown_neg;
    logic [4:0]  win_start;
    logic [4:0]  win_end;
    logic [5:0]  run_len;
    logic [2:0]  sched_mode;
  } cfg_t;

  typedef struct packed {
    logic [SWITCH_WIDTH-1:0] last_switches;
    logic                    seen_before;
    logic [31:0]             deadline;
    logic [1:0]              last_speed;
  } state_t;

  typedef struct packed {
    logic [1:0] fan_speed;
    logic [2:0] decided_by;
  } result_t;

endpackage

// ----- hdl/ventilation_fan_speed_decider_top.sv -----
// Fan speed decider. Each evaluation transaction (CO2 reading, switch mask, ms time,
// hour, minute) yields one result transaction (fan speed, deciding rule). An item is
// registered on acceptance and decided once the output register is free; its result is
// then registered onto the outputs. One item per cycle is sustained while out_ready
// holds, limited by the speed, switch and cooldown state each decision hands to the next.
// Registers sit on the APB port at byte address 4*index.
module ventilation_fan_speed_decider_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vfsd_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [16:0]                  co2_level,
  input  logic [7:0]                          switch_mask,
  input  logic [31:0]                         now_ms,
  input  logic [4:0]                          hour_of_day,
  input  logic [5:0]                          minute_of_hour,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          fan_speed,
  output logic [2:0]                          decided_by
);
  import vfsd_pkg::*;

  cfg_t        cfg;
  logic [10:0] cooldown_minutes;
  reg_index_t  wr_index;
  logic        wr_en;

  state_t      state;
  state_t      state_next;
  result_t     result;

  logic               item_valid;
  logic signed [16:0] item_co2;
  logic [7:0]         item_switches;
  logic [31:0]        item_now;
  logic [4:0]         item_hour;
  logic [5:0]         item_minute;
  logic               decide;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;
  assign wr_index = reg_index_t'(paddr[APB_ADDR_WIDTH-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.co2_hi <= CO2_HIGH_RESET;
      cfg.co2_low <= CO2_LOW_RESET;
      cfg.co2_hyst <= CO2_HYST_RESET;
      cfg.cooldown_ms <= COOLDOWN_MS_RESET;
      cfg.cooldown_neg <= 32'd0 - COOLDOWN_MS_RESET;
      cfg.win_start <= 5'd0;
      cfg.win_end <= 5'd0;
      cfg.run_len <= 6'd0;
      cfg.sched_mode <= 3'd0;
      cooldown_minutes <= COOLDOWN_MIN_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_CO2_HIGH: cfg.co2_hi <= pwdata[15:0];
        REG_CO2_LOW: cfg.co2_low <= pwdata[15:0];
        REG_CO2_HYST: cfg.co2_hyst <= pwdata[15:0];
        REG_COOLDOWN: begin
          cooldown_minutes <= pwdata[10:0];
          cfg.cooldown_ms <= {21'd0, pwdata[10:0]} * MS_PER_MINUTE;
          cfg.cooldown_neg <= 32'd0 - ({21'd0, pwdata[10:0]} * MS_PER_MINUTE);
        end
        REG_WIN_START: cfg.win_start <= pwdata[4:0];
        REG_WIN_END: cfg.win_end <= pwdata[4:0];
        REG_RUN_MINUTES: cfg.run_len <= pwdata[5:0];
        REG_SCHED_MODE: cfg.sched_mode <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_index)
      REG_CO2_HIGH: prdata = {16'd0, cfg.co2_hi};
      REG_CO2_LOW: prdata = {16'd0, cfg.co2_low};
      REG_CO2_HYST: prdata = {16'd0, cfg.co2_hyst};
      REG_COOLDOWN: prdata = {21'd0, cooldown_minutes};
      REG_WIN_START: prdata = {27'd0, cfg.win_start};
      REG_WIN_END: prdata = {27'd0, cfg.win_end};
      REG_RUN_MINUTES: prdata = {26'd0, cfg.run_len};
      REG_SCHED_MODE: prdata = {29'd0, cfg.sched_mode};
      default: prdata = 32'd0;
    endcase
  end

  assign decide = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || decide;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_co2 <= co2_level;
      item_switches <= switch_mask;
      item_now <= now_ms;
      item_hour <= hour_of_day;
      item_minute <= minute_of_hour;
    end
  end

  vfsd_decide u_decide (
    .cfg            (cfg),
    .state          (state),
    .co2_level      (item_co2),
    .switch_mask    (item_switches),
    .now_ms         (item_now),
    .hour_of_day    (item_hour),
    .minute_of_hour (item_minute),
    .result         (result),
    .state_next     (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (decide) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (decide) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide) begin
      fan_speed <= result.fan_speed;
      decided_by <= result.decided_by;
    end
  end

endmodule

// ----- hdl/vfsd_decide.sv -----
module vfsd_decide (
  input  vfsd_pkg::cfg_t    cfg,
  input  vfsd_pkg::state_t  state,
  input  logic signed [16:0] co2_level,
  input  logic [7:0]        switch_mask,
  input  logic [31:0]       now_ms,
  input  logic [4:0]        hour_of_day,
  input  logic [5:0]        minute_of_hour,
  output vfsd_pkg::result_t result,
  output vfsd_pkg::state_t  state_next
);
  import vfsd_pkg::*;

  logic [SWITCH_WIDTH-1:0] sw;
  logic                    release_edge;
  logic [31:0]             deadline_cand;
  logic [31:0]             diff;
  logic                    cooling;
  logic                    in_window;
  logic signed [17:0]      co2_ext;
  logic signed [17:0]      hi_level;
  logic signed [17:0]      lo_level;
  logic                    co2_over_hi;
  logic                    co2_low;
  logic                    sched_run;
  logic [1:0]              sched_speed;

  always_comb begin
    sw = switch_mask & SWITCH_MASK;
    release_edge = state.seen_before && (state.last_switches != '0);
    deadline_cand = release_edge ? (now_ms + cfg.cooldown_ms) : state.deadline;
    diff = release_edge ? cfg.cooldown_neg : (now_ms - state.deadline);
    cooling = (deadline_cand != 32'd0) && diff[31];

    if (cfg.win_start > cfg.win_end) begin
      in_window = (hour_of_day >= cfg.win_start) || (hour_of_day < cfg.win_end);
    end else begin
      in_window = (hour_of_day >= cfg.win_start) && (hour_of_day < cfg.win_end);
    end

    co2_ext = 18'(co2_level);
    hi_level = $signed({2'b00, cfg.co2_hi})
             - $signed({2'b00, ((state.last_speed == FAN_HIGH) ? cfg.co2_hyst : 16'd0)});
    lo_level = $signed({2'b00, cfg.co2_low})
             - $signed({2'b00, ((state.last_speed == FAN_HIGH ||
                                 state.last_speed == FAN_LOW) ? cfg.co2_hyst : 16'd0)});
    co2_over_hi = !co2_level[16] && (co2_ext > hi_level);
    co2_low = !co2_level[16] && (co2_ext >= lo_level);

    sched_run = (cfg.run_len != 6'd0) && in_window && (minute_of_hour < cfg.run_len);
    sched_speed = (cfg.sched_mode[1:0] == SPEED_UNUSED) ? FAN_OFF : cfg.sched_mode[1:0];

    state_next.last_switches = sw;
    state_next.seen_before = 1'b1;
    state_next.deadline = 32'd0;

    if (sw != '0) begin
      result.fan_speed = FAN_HIGH;
      result.decided_by = BY_SWITCH;
    end else if (cooling) begin
      result.fan_speed = FAN_HIGH;
      result.decided_by = BY_COOLDOWN;
      state_next.deadline = deadline_cand;
    end else if (co2_over_hi) begin
      result.fan_speed = (cfg.sched_mode[2] && in_window) ? FAN_LOW : FAN_HIGH;
      result.decided_by = BY_CO2;
    end else if (co2_low) begin
      result.fan_speed = FAN_LOW;
      result.decided_by = BY_CO2;
    end else if (sched_run) begin
      result.fan_speed = sched_speed;
      result.decided_by = BY_SCHEDULE;
    end else begin
      result.fan_speed = FAN_OFF;
      result.decided_by = BY_DEFAULT;
    end

    state_next.last_speed = result.fan_speed;
  end

endmodule
